// ===== design/euler_relative_target_vector_assert.svh =====
// ---------------------------------------------------------------------------
// euler_relative_target_vector assertion macros
// Shared check forms for the relative target vector block.
// ---------------------------------------------------------------------------
`ifndef EULER_RELATIVE_TARGET_VECTOR_ASSERT_SVH
`define EULER_RELATIVE_TARGET_VECTOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ERTV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ertv check failed");

// next-cycle implication, disabled in reset
`define ERTV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ertv check failed");

`endif

// ===== design/ertv_pkg.sv =====
// ---------------------------------------------------------------------------
// ertv_pkg
// Constants and types for the relative target vector block.
// ---------------------------------------------------------------------------
`default_nettype none

package ertv_pkg;

    // pipeline depth, input register to output register
    localparam int NSTG = 12;

    // quarter-wave sine polynomial, Q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42047;
    localparam logic [12:0] SIN_C = 13'd4640;

    localparam int NLANE = 6;

    typedef enum logic [1:0] {
        REG_TARGET_EAST  = 2'd0,
        REG_TARGET_NORTH = 2'd1,
        REG_TARGET_UP    = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [32:0] e;
        logic signed [32:0] n;
        logic signed [32:0] u;
    } diff_t;

endpackage

`default_nettype wire

// ===== design/euler_relative_target_vector.sv =====
// ---------------------------------------------------------------------------
// euler_relative_target_vector
// Rotates (target - vehicle position) into the camera frame by yaw/pitch/roll.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one pose beat: east, north, up
//   position (Q15.16) and yaw, pitch, roll binary angles. Output channel
//   (out_valid/out_ready) carries rel_x, rel_y, rel_z (Q15.16, saturated).
//   The target point is written through cfg_wr_en/cfg_index/cfg_data while
//   no beat is in flight; index 3 is ignored.
//   Throughput: one beat per cycle while the output register is empty or
//   out_ready is high. The depth is set by the chain of four multiplies
//   of the sine polynomial followed by the coefficient products, the nine
//   coefficient-by-difference multiplies, the sums and the final rounding.
//   Reset clears the target to zero and empties the pipeline.
//   When the receiver stalls with a result held, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module euler_relative_target_vector (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] pos_east,
    input  wire logic signed [31:0] pos_north,
    input  wire logic signed [31:0] pos_up,
    input  wire logic signed [15:0] yaw_angle,
    input  wire logic signed [15:0] pitch_angle,
    input  wire logic signed [15:0] roll_angle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      rel_x,
    output logic signed [31:0]      rel_y,
    output logic signed [31:0]      rel_z
);

    import ertv_pkg::*;

    // lane order: sin yaw, cos yaw, sin pitch, cos pitch, sin roll, cos roll
    localparam int SY = 0, CY = 1, SP = 2, CP = 3, SR = 4, CR = 5;

    logic signed [31:0] tgt_e_reg, tgt_n_reg, tgt_u_reg;
    logic [NSTG-1:0]    vld_reg;
    logic               adv;

    // whole pipeline advances together; last stage is the output register
    assign adv       = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NSTG-1];

    // target registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_e_reg <= '0;
            tgt_n_reg <= '0;
            tgt_u_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TARGET_EAST:  tgt_e_reg <= cfg_data;
                REG_TARGET_NORTH: tgt_n_reg <= cfg_data;
                REG_TARGET_UP:    tgt_u_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // ---------------- stage 1: differences, angle folding ----------------
    logic [15:0] ang [NLANE];
    always_comb
    begin
        ang[SY] = yaw_angle;
        ang[CY] = yaw_angle + 16'h4000;
        ang[SP] = pitch_angle;
        ang[CP] = pitch_angle + 16'h4000;
        ang[SR] = roll_angle;
        ang[CR] = roll_angle + 16'h4000;
    end

    diff_t       diff_reg [9];
    logic [14:0] t1_reg  [NLANE];
    logic [14:0] t2_reg  [NLANE];
    logic [14:0] t3_reg  [NLANE];
    logic [14:0] t4_reg  [NLANE];
    logic [NLANE-1:0] neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [28:0] tt_reg  [NLANE];
    logic [14:0] x2_reg  [NLANE];
    logic [27:0] m1_reg  [NLANE];
    logic [29:0] m2_reg  [NLANE];
    logic [31:0] m3_reg  [NLANE];
    logic signed [15:0] trig_reg [NLANE];

    logic [28:0] x2_sum  [NLANE];
    logic [15:0] y2      [NLANE];
    logic [16:0] y4      [NLANE];
    logic [31:0] r_sum   [NLANE];
    logic [15:0] r_clamp [NLANE];

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            x2_sum[i]  = tt_reg[i] + 29'd8192;
            y2[i]      = SIN_B - 16'(m1_reg[i] >> 14);
            y4[i]      = SIN_A - 17'(m2_reg[i] >> 14);
            r_sum[i]   = m3_reg[i] + 32'd16384;
            r_clamp[i] = (r_sum[i][31:15] > 17'd32767) ? 16'd32767 : r_sum[i][30:15];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg[0].e <= 33'(tgt_e_reg) - 33'(pos_east);
            diff_reg[0].n <= 33'(tgt_n_reg) - 33'(pos_north);
            diff_reg[0].u <= 33'(tgt_u_reg) - 33'(pos_up);
            for (int k = 1; k < 9; k++)
                diff_reg[k] <= diff_reg[k-1];
            for (int i = 0; i < NLANE; i++)
            begin
                // mirror odd quadrants, negate the lower half circle
                t1_reg[i]   <= ang[i][14] ? (15'd16384 - 15'(ang[i][13:0]))
                                          : 15'(ang[i][13:0]);
                neg1_reg[i] <= ang[i][15];
                // stage 2: t squared
                tt_reg[i]   <= 29'(t1_reg[i]) * 29'(t1_reg[i]);
                t2_reg[i]   <= t1_reg[i];
                neg2_reg[i] <= neg1_reg[i];
                // stage 3: x2 and C*x2
                x2_reg[i]   <= x2_sum[i][28:14];
                m1_reg[i]   <= 28'(SIN_C) * 28'(x2_sum[i][28:14]);
                t3_reg[i]   <= t2_reg[i];
                neg3_reg[i] <= neg2_reg[i];
                // stage 4: (B - C*x2) * x2
                m2_reg[i]   <= 30'(y2[i]) * 30'(x2_reg[i]);
                t4_reg[i]   <= t3_reg[i];
                neg4_reg[i] <= neg3_reg[i];
                // stage 5: (A - ...) * t
                m3_reg[i]   <= 32'(y4[i]) * 32'(t4_reg[i]);
                neg5_reg[i] <= neg4_reg[i];
                // stage 6: round, clamp, sign
                trig_reg[i] <= neg5_reg[i] ? -signed'(r_clamp[i]) : signed'(r_clamp[i]);
            end
        end
    end

    // ---------------- stage 7: two-factor products ----------------
    // p2 index: 0 cp*cy, 1 sy*cr, 2 sr*sy, 3 sy*cp, 4 cr*cy, 5 sr*cy,
    //           6 sr*cp, 7 cp*cr
    logic signed [31:0] pp [8];
    logic signed [31:0] p2_sum [8];
    always_comb
    begin
        pp[0] = 32'(trig_reg[CP]) * 32'(trig_reg[CY]);
        pp[1] = 32'(trig_reg[SY]) * 32'(trig_reg[CR]);
        pp[2] = 32'(trig_reg[SR]) * 32'(trig_reg[SY]);
        pp[3] = 32'(trig_reg[SY]) * 32'(trig_reg[CP]);
        pp[4] = 32'(trig_reg[CR]) * 32'(trig_reg[CY]);
        pp[5] = 32'(trig_reg[SR]) * 32'(trig_reg[CY]);
        pp[6] = 32'(trig_reg[SR]) * 32'(trig_reg[CP]);
        pp[7] = 32'(trig_reg[CP]) * 32'(trig_reg[CR]);
        for (int i = 0; i < 8; i++)
            p2_sum[i] = pp[i] + 32'sd512;
    end

    logic signed [20:0] p2_reg  [8];
    logic signed [20:0] p2b_reg [8];
    logic signed [31:0] raw_reg [3];   // sp*sr, sp*cr, sp*sy
    logic signed [15:0] cy7_reg, sy7_reg, cr7_reg, sp7_reg, sp8_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 8; i++)
                p2_reg[i] <= p2_sum[i][30:10];
            raw_reg[0] <= 32'(trig_reg[SP]) * 32'(trig_reg[SR]);
            raw_reg[1] <= 32'(trig_reg[SP]) * 32'(trig_reg[CR]);
            raw_reg[2] <= 32'(trig_reg[SP]) * 32'(trig_reg[SY]);
            cy7_reg    <= trig_reg[CY];
            sy7_reg    <= trig_reg[SY];
            cr7_reg    <= trig_reg[CR];
            sp7_reg    <= trig_reg[SP];
        end
    end

    // ---------------- stage 8: three-factor products ----------------
    // p3 index: 0 sp*sr*cy, 1 sp*cr*cy, 2 sp*sr*sy, 3 sp*sy*cr
    logic signed [47:0] p3_sum [4];
    always_comb
    begin
        p3_sum[0] = 48'(raw_reg[0]) * 48'(cy7_reg) + 48'sd16777216;
        p3_sum[1] = 48'(raw_reg[1]) * 48'(cy7_reg) + 48'sd16777216;
        p3_sum[2] = 48'(raw_reg[0]) * 48'(sy7_reg) + 48'sd16777216;
        p3_sum[3] = 48'(raw_reg[2]) * 48'(cr7_reg) + 48'sd16777216;
    end

    logic signed [20:0] p3_reg [4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                p3_reg[i] <= p3_sum[i][45:25];
            p2b_reg <= p2_reg;
            sp8_reg <= sp7_reg;
        end
    end

    // ---------------- stage 9: matrix coefficients, Q20 ----------------
    // coef index: 0 xe, 1 xn, 2 xu, 3 ye, 4 yn, 5 yu, 6 ze, 7 zn, 8 zu
    logic signed [22:0] coef_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coef_reg[0] <= -23'(p2b_reg[0]);
            coef_reg[1] <= -(23'(p2b_reg[1]) + 23'(p3_reg[0]));
            coef_reg[2] <= -(23'(p2b_reg[2]) - 23'(p3_reg[1]));
            coef_reg[3] <= -23'(p2b_reg[3]);
            coef_reg[4] <= 23'(p2b_reg[4]) - 23'(p3_reg[2]);
            coef_reg[5] <= 23'(p2b_reg[5]) + 23'(p3_reg[3]);
            coef_reg[6] <= -(23'(sp8_reg) <<< 5);
            coef_reg[7] <= 23'(p2b_reg[6]);
            coef_reg[8] <= -23'(p2b_reg[7]);
        end
    end

    // ---------------- stage 10: coefficient times difference ----------------
    logic signed [55:0] prod_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[3*r+0] <= 56'(coef_reg[3*r+0]) * 56'(diff_reg[8].e);
                prod_reg[3*r+1] <= 56'(coef_reg[3*r+1]) * 56'(diff_reg[8].n);
                prod_reg[3*r+2] <= 56'(coef_reg[3*r+2]) * 56'(diff_reg[8].u);
            end
        end
    end

    // ---------------- stage 11: row sums, Q36 ----------------
    logic signed [57:0] acc_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= 58'(prod_reg[3*r]) + 58'(prod_reg[3*r+1])
                            + 58'(prod_reg[3*r+2]);
        end
    end

    // ---------------- stage 12: round to Q16, saturate ----------------
    logic signed [57:0] rnd_sum [3];
    logic signed [37:0] rnd_val [3];
    logic signed [31:0] sat_val [3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd_sum[r] = acc_reg[r] + 58'sd524288;
            rnd_val[r] = rnd_sum[r][57:20];
            if (rnd_val[r] > 38'sd2147483647)
                sat_val[r] = 32'sh7FFFFFFF;
            else if (rnd_val[r] < -38'sd2147483648)
                sat_val[r] = 32'sh80000000;
            else
                sat_val[r] = rnd_val[r][31:0];
        end
    end

    logic signed [31:0] rel_x_reg, rel_y_reg, rel_z_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rel_x_reg <= sat_val[0];
            rel_y_reg <= sat_val[1];
            rel_z_reg <= sat_val[2];
        end
    end

    assign rel_x = rel_x_reg;
    assign rel_y = rel_y_reg;
    assign rel_z = rel_z_reg;

    // ---------------- checks ----------------
    `include "euler_relative_target_vector_assert.svh"

    `ERTV_ASSERT_NEXT(a_enter, in_valid && in_ready, vld_reg[0])
    `ERTV_ASSERT_NEXT(a_hold, !in_ready, $stable(vld_reg))
    `ERTV_ASSERT_NEXT(a_leave, vld_reg[NSTG-2] && in_ready, out_valid)

endmodule

`default_nettype wire

// ===== verif/tb_euler_relative_target_vector.sv =====
// ---------------------------------------------------------------------------
// tb_euler_relative_target_vector
// Self-checking bench for the relative target vector block: drives random
// and directed pose beats with random gaps on both channels, predicts each
// camera-frame vector in fixed point and compares it with the output beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_euler_relative_target_vector;
    import ertv_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] east;
        logic signed [31:0] north;
        logic signed [31:0] up;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } pose_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = REG_TARGET_EAST;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] pos_east = '0;
    logic signed [31:0] pos_north = '0;
    logic signed [31:0] pos_up = '0;
    logic signed [15:0] yaw_angle = '0;
    logic signed [15:0] pitch_angle = '0;
    logic signed [15:0] roll_angle = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;

    // testbench copy of the target registers
    longint target_e = 0;
    longint target_n = 0;
    longint target_u = 0;

    pose_t pending_poses[$];
    vec_t expected_vectors[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit long_hold_req = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    always #1 clk = ~clk;

    euler_relative_target_vector u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_east(pos_east), .pos_north(pos_north), .pos_up(pos_up),
        .yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .rel_x(rel_x), .rel_y(rel_y), .rel_z(rel_z)
    );

    // floor((v + half) / 2^s); >>> on longint is an arithmetic floor shift
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint quarter_sine(longint t);
        longint x2;
        longint y;
        longint r;
        x2 = (t * t + 8192) >> 14;
        y = (4640 * x2) >> 14;
        y = 42047 - y;
        y = (y * x2) >> 14;
        y = 102944 - y;
        r = (y * t + 16384) >> 15;
        if (r > 32767)
            r = 32767;
        return r;
    endfunction

    function automatic longint angle_sine(logic [15:0] a);
        logic [1:0] quad;
        longint frac;
        longint v;
        quad = a[15:14];
        frac = a[13:0];
        v = quarter_sine(quad[0] ? 16384 - frac : frac);
        return quad[1] ? -v : v;
    endfunction

    function automatic logic signed [31:0] saturate_q16(longint acc);
        longint r;
        r = round_shift(acc, 20);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic vec_t camera_vector(pose_t p);
        longint de, dn, du, sy, cy, sp, cp, sr, cr;
        longint xe, xn, xu, ye, yn, yu, ze, zn, zu;
        vec_t v;
        de = target_e - longint'(p.east);
        dn = target_n - longint'(p.north);
        du = target_u - longint'(p.up);
        sy = angle_sine(p.yaw);
        cy = angle_sine(p.yaw + 16'h4000);
        sp = angle_sine(p.pitch);
        cp = angle_sine(p.pitch + 16'h4000);
        sr = angle_sine(p.roll);
        cr = angle_sine(p.roll + 16'h4000);
        // Q20 coefficients: pairs drop 10 bits, triples drop 25
        xe = -round_shift(cp * cy, 10);
        xn = -(round_shift(sy * cr, 10) + round_shift(sp * sr * cy, 25));
        xu = -(round_shift(sr * sy, 10) - round_shift(sp * cr * cy, 25));
        ye = -round_shift(sy * cp, 10);
        yn = round_shift(cr * cy, 10) - round_shift(sp * sr * sy, 25);
        yu = round_shift(sr * cy, 10) + round_shift(sp * sy * cr, 25);
        ze = -(sp * 32);
        zn = round_shift(sr * cp, 10);
        zu = -round_shift(cp * cr, 10);
        v.x = saturate_q16(xe * de + xn * dn + xu * du);
        v.y = saturate_q16(ye * de + yn * dn + yu * du);
        v.z = saturate_q16(ze * de + zn * dn + zu * du);
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] random_position();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
        endcase
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        p.east = random_position();
        p.north = random_position();
        p.up = random_position();
        p.yaw = $urandom();
        p.pitch = $urandom();
        p.roll = $urandom();
        return p;
    endfunction

    function automatic pose_t make_pose(logic [31:0] e, logic [31:0] n, logic [31:0] u,
                                        logic [15:0] y, logic [15:0] pt, logic [15:0] r);
        pose_t p;
        p.east = e; p.north = n; p.up = u;
        p.yaw = y; p.pitch = pt; p.roll = r;
        return p;
    endfunction

    // driver: advance through the pending queue, hold valid until accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_poses.size() > 0)
                begin
                    pose_t p;
                    p = pending_poses.pop_front();
                    in_valid <= 1'b1;
                    pos_east <= p.east;
                    pos_north <= p.north;
                    pos_up <= p.up;
                    yaw_angle <= p.yaw;
                    pitch_angle <= p.pitch;
                    roll_angle <= p.roll;
                    expected_vectors.push_back(camera_vector(p));
                    send_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each output beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                vec_t exp_v;
                if (expected_vectors.size() == 0)
                begin
                    $display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time,
                             rel_x, rel_y, rel_z);
                    mismatches++;
                end
                else
                begin
                    exp_v = expected_vectors.pop_front();
                    if (rel_x !== exp_v.x)
                    begin
                        $display("%0t: rel_x expected %0d actual %0d", $time, exp_v.x, rel_x);
                        mismatches++;
                    end
                    if (rel_y !== exp_v.y)
                    begin
                        $display("%0t: rel_y expected %0d actual %0d", $time, exp_v.y, rel_y);
                        mismatches++;
                    end
                    if (rel_z !== exp_v.z)
                    begin
                        $display("%0t: rel_z expected %0d actual %0d", $time, exp_v.z, rel_z);
                        mismatches++;
                    end
                end
            end
            // receiver: long hold on request, else random stalls
            if (long_hold_req)
            begin
                long_hold_req <= 1'b0;
                recv_gap <= 60;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap <= pick_gap();
            end
            // watchdog: count cycles with no accepted beat on either side
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // wait until all queued beats are out and all predictions consumed
    task automatic drain();
        while (pending_poses.size() > 0 || in_valid || expected_vectors.size() > 0)
            @(posedge clk);
        repeat (NSTG + 4) @(posedge clk);
    endtask

    task automatic write_target(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TARGET_EAST:  target_e = longint'(signed'(value));
            REG_TARGET_NORTH: target_n = longint'(signed'(value));
            REG_TARGET_UP:    target_u = longint'(signed'(value));
            default: ;
        endcase
    endtask

    task automatic set_targets(logic [31:0] e, logic [31:0] n, logic [31:0] u);
        write_target(REG_TARGET_EAST, e);
        write_target(REG_TARGET_NORTH, n);
        write_target(REG_TARGET_UP, u);
    endtask

    initial
    begin
        int phase;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset targets, angle extremes, -pi, unity trig, big differences
        pending_poses.push_back(make_pose(0, 0, 0, 0, 0, 0));
        pending_poses.push_back(make_pose(32'h00010000, 32'h00020000, 32'hFFFF0000,
                                          0, 0, 0));
        pending_poses.push_back(make_pose(32'h00010000, 32'h00020000, 32'h00030000,
                                          16'h8000, 16'h8000, 16'h8000));
        pending_poses.push_back(make_pose(32'h00010000, 32'h00020000, 32'h00030000,
                                          16'h4000, 16'hC000, 16'h4000));
        pending_poses.push_back(make_pose(32'h00010000, 32'h00020000, 32'h00030000,
                                          16'h7FFF, 16'h7FFF, 16'h7FFF));
        pending_poses.push_back(make_pose(32'h00050000, 32'h00010000, 32'h00030000,
                                          16'h2000, 16'h1000, 16'hE000));
        pending_poses.push_back(make_pose(32'h80000000, 32'h80000000, 32'h80000000,
                                          16'h0001, 16'hFFFF, 16'h3FFF));
        pending_poses.push_back(make_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                          16'h4001, 16'hBFFF, 16'h8001));
        pending_poses.push_back(make_pose(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                                          16'h5555, 16'hAAAA, 16'h0000));
        drain();

        // extreme targets against extreme positions drive saturation
        set_targets(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        write_target(REG_UNUSED, 32'h12345678);
        pending_poses.push_back(make_pose(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                          0, 0, 0));
        pending_poses.push_back(make_pose(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                          16'h8000, 16'h4000, 16'hC000));
        pending_poses.push_back(make_pose(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                          16'h2000, 16'h2000, 16'h2000));
        pending_poses.push_back(make_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                          16'h1234, 16'h8765, 16'h4321));
        drain();

        // random phases with fresh targets; one phase with a long receiver hold
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_targets(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
            else
                set_targets(random_position(), random_position(), random_position());
            repeat (190)
                pending_poses.push_back(random_pose());
            if (phase == 2)
            begin
                // let the pipe fill against a stalled receiver
                long_hold_req <= 1'b1;
            end
            drain();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/ertv_pkg.sv
design/euler_relative_target_vector.sv
verif/tb_euler_relative_target_vector.sv
